/* rtl/tsv_pkg.sv */
package tsv_pkg;

  // window and metric sizing
  localparam int WINDOW_LEN   = 32;
  localparam int METRIC_WIDTH = 28;
  localparam int DATA_W       = 24;
  localparam int PTR_W        = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CAND_W       = METRIC_WIDTH + 3;
  localparam int PATH_W       = 32;

  // stream widths
  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_TDATA_W = ((PATH_W + 1 + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_UNV_FROM_UNV = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_UNV_FROM_VOI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_VOI_FROM_UNV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_VOI_FROM_VOI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_METRIC_UNV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_METRIC_VOI    = 3'd5;

  // largest positive metric, at candidate width
  localparam logic signed [CAND_W-1:0] METRIC_MAX =
    {{(CAND_W - METRIC_WIDTH + 1){1'b0}}, {(METRIC_WIDTH - 1){1'b1}}};

  // one frame of emission log-likelihoods
  typedef struct packed {
    logic signed [DATA_W-1:0] loglik_voiced;
    logic signed [DATA_W-1:0] loglik_unvoiced;
  } item_t;

  // configuration registers as seen by the decoder core
  typedef struct packed {
    logic signed [DATA_W-1:0] trans_unv_from_unv;
    logic signed [DATA_W-1:0] trans_unv_from_voi;
    logic signed [DATA_W-1:0] trans_voi_from_unv;
    logic signed [DATA_W-1:0] trans_voi_from_voi;
    logic signed [DATA_W-1:0] init_metric_unv;
    logic signed [DATA_W-1:0] init_metric_voi;
  } cfg_t;

endpackage

/* rtl/two_state_viterbi_sliding_traceback.sv */
// channel  | direction | handshake                     | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: loglik_unvoiced, loglik_voiced
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: path_bits, best_state, pad
// cfg      | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// each item passes in order through add-compare-select, renormalization, a traceback walk
// back through the survivor rows and a load of the result register; the core takes no new
// item until that load is done, so the traceback walk sets the rate
// reset clears metrics, survivor rows and pointers at once, no clearing pass
// a two-item input queue and a result register let either side stall on its own
module two_state_viterbi_sliding_traceback (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // loglik_unvoiced [23:0], loglik_voiced [47:24]
  input  logic [tsv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // path_bits [31:0], best_state [32], zero [39:33]
  output logic [tsv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tsv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tsv_pkg::DATA_W-1:0]          cfg_data_i
);

  tsv_pkg::cfg_t                cfg_q;
  tsv_pkg::item_t               item;
  logic                         item_valid, item_ready;
  logic [tsv_pkg::PATH_W-1:0]   out_path;
  logic                         out_best;

  assign cfg_ready_o = 1'b1;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tsv_pkg::REG_TRANS_UNV_FROM_UNV: cfg_q.trans_unv_from_unv <= cfg_data_i;
        tsv_pkg::REG_TRANS_UNV_FROM_VOI: cfg_q.trans_unv_from_voi <= cfg_data_i;
        tsv_pkg::REG_TRANS_VOI_FROM_UNV: cfg_q.trans_voi_from_unv <= cfg_data_i;
        tsv_pkg::REG_TRANS_VOI_FROM_VOI: cfg_q.trans_voi_from_voi <= cfg_data_i;
        tsv_pkg::REG_INIT_METRIC_UNV:    cfg_q.init_metric_unv    <= cfg_data_i;
        tsv_pkg::REG_INIT_METRIC_VOI:    cfg_q.init_metric_voi    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input queue
  tsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // decoder core
  tsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_path_o   (out_path),
    .out_best_o   (out_best)
  );

  // pack the result word
  assign m_axis_tdata = tsv_pkg::OUT_TDATA_W'({out_best, out_path});

endmodule

/* rtl/tsv_front.sv */
module tsv_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic [tsv_pkg::IN_TDATA_W-1:0]    s_data_i,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output tsv_pkg::item_t                    item_o
);

  tsv_pkg::item_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;
  tsv_pkg::item_t in_item;

  // split the incoming word into its fields
  assign in_item.loglik_unvoiced = s_data_i[tsv_pkg::DATA_W-1:0];
  assign in_item.loglik_voiced   = s_data_i[2*tsv_pkg::DATA_W-1:tsv_pkg::DATA_W];

  assign s_ready_o    = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  assign push = s_valid_i && s_ready_o;
  assign pop  = item_valid_o && item_ready_i;

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

  // fill level never passes two, and pointers differ by the fill level
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue fill level out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill level");

endmodule

/* rtl/tsv_back.sv */
module tsv_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsv_pkg::cfg_t                cfg_i,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  tsv_pkg::item_t               item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tsv_pkg::PATH_W-1:0]   out_path_o,
  output logic                         out_best_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_TRACE,
    ST_DONE
  } state_e;

  localparam logic [tsv_pkg::PTR_W-1:0] PTR_LAST = tsv_pkg::PTR_W'(tsv_pkg::WINDOW_LEN - 1);
  localparam logic [tsv_pkg::PTR_W-1:0] CNT_LAST = tsv_pkg::PTR_W'(tsv_pkg::WINDOW_LEN - 2);

  state_e                                  state_q;
  logic                                    primed_q;
  logic signed [tsv_pkg::METRIC_WIDTH-1:0] metric_q [2];
  logic [1:0]                              store_q [tsv_pkg::WINDOW_LEN];
  logic [tsv_pkg::PTR_W-1:0]               wptr_q;
  logic [tsv_pkg::PTR_W-1:0]               rptr_q;
  logic [tsv_pkg::PTR_W-1:0]               cnt_q;
  logic                                    out_valid_q;
  logic [tsv_pkg::PATH_W-1:0]              out_path_q;
  logic                                    out_best_q;

  logic signed [tsv_pkg::CAND_W-1:0]       next_q [2];
  logic [tsv_pkg::WINDOW_LEN-1:0]          tb_bits_q;
  logic                                    tb_state_q;
  logic                                    best_q;

  logic signed [tsv_pkg::CAND_W-1:0] prev0, prev1;
  logic signed [tsv_pkg::CAND_W-1:0] c00, c01, c10, c11;
  logic signed [tsv_pkg::CAND_W-1:0] lo, v0, v1, m0, m1;
  logic                              sel0, sel1, best, tb_next, take, load;
  logic [tsv_pkg::PTR_W-1:0]         wptr_inc, rptr_dec;

  // add-compare-select on the popped frame
  always_comb begin
    prev0 = primed_q ? tsv_pkg::CAND_W'(metric_q[0]) : tsv_pkg::CAND_W'(cfg_i.init_metric_unv);
    prev1 = primed_q ? tsv_pkg::CAND_W'(metric_q[1]) : tsv_pkg::CAND_W'(cfg_i.init_metric_voi);
    c00 = prev0 + tsv_pkg::CAND_W'(cfg_i.trans_unv_from_unv)
        + tsv_pkg::CAND_W'(item_i.loglik_unvoiced);
    c01 = prev1 + tsv_pkg::CAND_W'(cfg_i.trans_unv_from_voi)
        + tsv_pkg::CAND_W'(item_i.loglik_unvoiced);
    c10 = prev0 + tsv_pkg::CAND_W'(cfg_i.trans_voi_from_unv)
        + tsv_pkg::CAND_W'(item_i.loglik_voiced);
    c11 = prev1 + tsv_pkg::CAND_W'(cfg_i.trans_voi_from_voi)
        + tsv_pkg::CAND_W'(item_i.loglik_voiced);
    sel0 = !(c00 > c01);
    sel1 = !(c10 > c11);
  end

  // best state and renormalization, ties go to voiced
  always_comb begin
    best = !(next_q[0] > next_q[1]);
    lo   = best ? next_q[0] : next_q[1];
    v0   = next_q[0] - lo;
    v1   = next_q[1] - lo;
    m0   = (v0 > tsv_pkg::METRIC_MAX) ? tsv_pkg::METRIC_MAX : v0;
    m1   = (v1 > tsv_pkg::METRIC_MAX) ? tsv_pkg::METRIC_MAX : v1;
  end

  // circular pointer steps and traceback lookup
  assign wptr_inc = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
  assign rptr_dec = (rptr_q == '0) ? PTR_LAST : rptr_q - 1'b1;
  assign tb_next  = store_q[rptr_q][tb_state_q];

  assign take = (state_q == ST_IDLE) && item_valid_i;
  assign load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign item_ready_o = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_path_o   = out_path_q;
  assign out_best_o   = out_best_q;

  // sequencer, metrics, survivor rows and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= 1'b0;
      metric_q[0] <= '0;
      metric_q[1] <= '0;
      for (int i = 0; i < tsv_pkg::WINDOW_LEN; i++) begin
        store_q[i] <= 2'b00;
      end
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_path_q  <= '0;
      out_best_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            store_q[wptr_q] <= {sel1, sel0};
            rptr_q          <= wptr_q;
            wptr_q          <= wptr_inc;
            primed_q        <= 1'b1;
            state_q         <= ST_NORM;
          end
        end
        ST_NORM: begin
          metric_q[0] <= tsv_pkg::METRIC_WIDTH'(m0);
          metric_q[1] <= tsv_pkg::METRIC_WIDTH'(m1);
          cnt_q       <= '0;
          state_q     <= ST_TRACE;
        end
        ST_TRACE: begin
          rptr_q <= rptr_dec;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            out_valid_q <= 1'b1;
            out_path_q  <= tsv_pkg::PATH_W'(tb_bits_q);
            out_best_q  <= best_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // candidate metrics and traceback shift register
  always_ff @(posedge clk_i) begin
    if (take) begin
      next_q[0] <= sel0 ? c01 : c00;
      next_q[1] <= sel1 ? c11 : c10;
    end
    if (state_q == ST_NORM) begin
      best_q     <= best;
      tb_state_q <= best;
      tb_bits_q  <= tsv_pkg::WINDOW_LEN'(best);
    end else if (state_q == ST_TRACE) begin
      tb_state_q <= tb_next;
      tb_bits_q  <= {tb_bits_q[tsv_pkg::WINDOW_LEN-2:0], tb_next};
    end
  end

  // after renormalization the smaller metric is zero
  a_renorm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM) |=> (metric_q[0] == '0 || metric_q[1] == '0))
    else $error("metrics not renormalized");

  // traceback ends after its last step
  a_trace_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRACE && cnt_q == CNT_LAST) |=> (state_q == ST_DONE))
    else $error("traceback did not finish on time");

  // write pointer stays inside the window
  a_wptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wptr_q <= PTR_LAST)
    else $error("write pointer outside window");

  // a pending result is never replaced
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_path_q)))
    else $error("pending result overwritten");

endmodule
